[rtl/tct_pkg.sv]
// package for the tcp connection tracker: codes, types, state functions
// used by tct_hash and tcp_connection_tracker
package tct_pkg;

   localparam int DEF_TABLE_ENTRIES = 1024;
   localparam int DEF_MAX_PROBES    = 8;
   localparam int KEY_W             = 48;

   typedef enum logic [1:0] {
      ACT_PACKET = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_CLEAR  = 2'd2,
      ACT_UNDEF  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_SYN_SENT    = 3'd0,
      ST_SYN_RCVD    = 3'd1,
      ST_ESTABLISHED = 3'd2,
      ST_CLOSING     = 3'd3,
      ST_RESET       = 3'd4,
      ST_CLOSED      = 3'd5
   } conn_state_type;

   typedef enum logic [2:0] {
      RS_UPDATED   = 3'd0,
      RS_CREATED   = 3'd1,
      RS_FULL      = 3'd2,
      RS_REMOVED   = 3'd3,
      RS_NOT_FOUND = 3'd4,
      RS_CLEARED   = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      FSM_IDLE,
      FSM_MIX,
      FSM_MUL,
      FSM_HASH,
      FSM_ISSUE,
      FSM_CHECK,
      FSM_DECIDE,
      FSM_WRITE,
      FSM_CLEAR,
      FSM_RESPOND
   } fsm_type;

   // input item
   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic        flag_syn;
      logic        flag_ack;
      logic        flag_fin;
      logic        flag_rst;
   } req_type;

   // result item
   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  conn_state;
      logic [15:0] conn_number;
      logic [31:0] packet_count;
   } rsp_type;

   // per-slot record held in memory
   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key_lo;
      logic [KEY_W-1:0] key_hi;
      logic [2:0]       conn_state;
      logic [15:0]      number;
      logic [31:0]      count;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // state advance for a packet on an existing entry
   function automatic logic [2:0] advance_state(logic [2:0] cur, logic syn, logic ack,
                                                logic fin, logic rst);
      logic [2:0] c;
      c = rst ? ST_RESET : cur;
      case (c)
         ST_SYN_SENT:    if (syn && ack) c = ST_SYN_RCVD;
         ST_SYN_RCVD:    if (ack) c = ST_ESTABLISHED;
         ST_ESTABLISHED: if (fin) c = ST_CLOSING;
         ST_CLOSING:     if (fin) c = ST_CLOSED;
         default:        c = c;
      endcase
      return c;
   endfunction

   // state for a new entry
   function automatic logic [2:0] initial_state(logic syn, logic ack, logic fin, logic rst);
      logic [2:0] c;
      if (syn)      c = ack ? ST_SYN_RCVD : ST_SYN_SENT;
      else if (rst) c = ST_RESET;
      else if (fin) c = ST_CLOSING;
      else          c = ST_ESTABLISHED;
      return c;
   endfunction

endpackage

[rtl/tct_stream_if.sv]
// valid/ready channel carrying one payload type
// no package dependency; the payload type is a parameter
interface tct_stream_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/tct_ram.sv]
// generic single-port ram with registered read
// no package dependency
module tct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data_ff <= mem[addr];
   end
   assign rd_data = rd_data_ff;
endmodule

[rtl/tct_hash.sv]
// key hash unit: 64x64 multiply split in 32x32 partial products over cycles
// depends on tct_pkg
module tct_hash #(
   parameter int TABLE_ENTRIES = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [tct_pkg::KEY_W-1:0]        key_lo,
   input  logic [tct_pkg::KEY_W-1:0]        key_hi,
   output logic                             done,
   output logic [$clog2(TABLE_ENTRIES)-1:0] base
);
   import tct_pkg::*;
   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;

   logic [63:0] x_ff, x_in;
   logic [63:0] acc_ff, acc_in;
   logic [1:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic [63:0] rot;
   logic [31:0] ma, mb;
   logic [63:0] prod;
   logic [63:0] hx;
   logic [47:0] sh;

   // xor of low key with rotated high key; the wrapped bits of a 48-bit key are zero
   assign rot = {16'd0, key_lo} ^ ({16'd0, key_hi} << 13);

   // one 32x32 multiplier shared over three partial products
   always_comb begin
      case (step_ff)
         2'd0:    begin ma = x_ff[31:0];  mb = GOLDEN[31:0];  end
         2'd1:    begin ma = x_ff[31:0];  mb = GOLDEN[63:32]; end
         default: begin ma = x_ff[63:32]; mb = GOLDEN[31:0];  end
      endcase
   end
   assign prod = {32'd0, ma} * {32'd0, mb};

   always_comb begin
      x_in = x_ff; acc_in = acc_ff; step_in = step_ff; busy_in = busy_ff;
      if (start) begin
         x_in = rot; acc_in = '0; step_in = 2'd0; busy_in = 1'b1;
      end else if (busy_ff) begin
         case (step_ff)
            2'd0:    acc_in = prod;
            default: acc_in = acc_ff + {prod[31:0], 32'd0};
         endcase
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd2) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; step_ff <= 2'd0;
      end else begin
         busy_ff <= busy_in; step_ff <= step_in;
      end
      x_ff <= x_in; acc_ff <= acc_in;
   end

   // finish: xor-shift and fold into table index
   assign hx   = acc_ff ^ (acc_ff >> 29);
   assign sh   = hx[63:16];
   assign base = sh[IDX_W-1:0];
   assign done = busy_ff == 1'b0 && step_ff == 2'd3;
endmodule

[rtl/tcp_connection_tracker.sv]
// channel | dir | payload
// req     | in  | action, src/dst addr, src/dst port, syn/ack/fin/rst
// rsp     | out | status, conn_state, conn_number, packet_count
// a packet, remove or undefined action goes from transfer to transfer through these steps:
// accept, key order, hash multiply, one read per probe, decide, write.
// clear writes every slot of the table, one per cycle.
// reset is synchronous; the same clearing pass follows it before req is ready.
// req is not ready while an item is in work; a stalled rsp holds the block.
// depends on tct_pkg, tct_stream_if, tct_hash, tct_ram
module tcp_connection_tracker #(
   parameter int TABLE_ENTRIES = tct_pkg::DEF_TABLE_ENTRIES,
   parameter int MAX_PROBES    = tct_pkg::DEF_MAX_PROBES
) (
   input logic   clock,
   input logic   reset,
   tct_stream_if.sink   req_ch,
   tct_stream_if.source rsp_ch
);
   import tct_pkg::*;
   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int PRB_W = $clog2(MAX_PROBES + 1);

   fsm_type     state_ff, state_in;
   req_type     req_ff;
   logic [KEY_W-1:0] lo_ff, hi_ff;
   logic [IDX_W-1:0] base_ff;
   logic [PRB_W-1:0] probe_ff, probe_in;
   logic [IDX_W-1:0] cur_ff;
   logic        found_ff, found_in, free_ff, free_in;
   logic [IDX_W-1:0] hit_ff, hit_in, free_slot_ff, free_slot_in;
   entry_type   hit_ent_ff, hit_ent_in;
   logic [IDX_W-1:0] clr_addr_ff;
   logic        clr_rsp_ff;
   logic [15:0] next_num_ff;
   rsp_type     rsp_ff, rsp_in;
   logic        hash_start, hash_done;
   logic [IDX_W-1:0] hash_base;
   logic        ram_we;
   logic [IDX_W-1:0] ram_addr;
   entry_type   ram_wdata, ram_rdata;
   logic [KEY_W-1:0] ka, kb;
   logic [IDX_W-1:0] probe_addr;
   logic        do_create, do_update, do_remove;

   assign ka = {req_ch.payload.src_addr, req_ch.payload.src_port};
   assign kb = {req_ch.payload.dst_addr, req_ch.payload.dst_port};

   tct_hash #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_hash (
      .clock(clock), .reset(reset), .start(hash_start),
      .key_lo(lo_ff), .key_hi(hi_ff), .done(hash_done), .base(hash_base));

   tct_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data(ram_wdata), .rd_data(ram_rdata));

   // probe address wraps modulo table size
   assign probe_addr = base_ff + IDX_W'(probe_ff);

   assign do_update = req_ff.action == ACT_PACKET && found_ff;
   assign do_create = req_ff.action == ACT_PACKET && !found_ff && free_ff;
   assign do_remove = req_ff.action == ACT_REMOVE && found_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE:    if (req_ch.valid) state_in = FSM_MIX;
         FSM_MIX:     state_in = (req_ff.action == ACT_CLEAR) ? FSM_CLEAR : FSM_MUL;
         FSM_MUL:     if (hash_done) state_in = FSM_HASH;
         FSM_HASH:    state_in = FSM_ISSUE;
         FSM_ISSUE:   state_in = FSM_CHECK;
         FSM_CHECK:   state_in = (probe_ff == PRB_W'(MAX_PROBES - 1)) ? FSM_DECIDE : FSM_ISSUE;
         FSM_DECIDE:  state_in = FSM_WRITE;
         FSM_WRITE:   state_in = FSM_RESPOND;
         FSM_CLEAR: begin
            if (clr_addr_ff == IDX_W'(TABLE_ENTRIES - 1))
               state_in = clr_rsp_ff ? FSM_RESPOND : FSM_IDLE;
         end
         FSM_RESPOND: if (rsp_ch.ready) state_in = FSM_IDLE;
         default:     state_in = FSM_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      hash_start = state_ff == FSM_MIX && req_ff.action != ACT_CLEAR;
      ram_we = 1'b0;
      ram_addr = cur_ff;
      ram_wdata = hit_ent_ff;
      if (state_ff == FSM_ISSUE) ram_addr = probe_addr;
      if (state_ff == FSM_WRITE && (do_update || do_create || do_remove)) begin
         ram_we = 1'b1;
         ram_addr = do_create ? free_slot_ff : hit_ff;
      end
      // clearing pass: one empty slot written per cycle
      if (state_ff == FSM_CLEAR) begin
         ram_we = 1'b1;
         ram_addr = clr_addr_ff;
         ram_wdata = '0;
      end
   end

   // probe evaluation and result build
   always_comb begin
      found_in = found_ff; free_in = free_ff; hit_in = hit_ff;
      free_slot_in = free_slot_ff; hit_ent_in = hit_ent_ff; probe_in = probe_ff;
      rsp_in = rsp_ff;
      case (state_ff)
         FSM_HASH: begin
            found_in = 1'b0; free_in = 1'b0; probe_in = '0;
         end
         FSM_CHECK: begin
            if (ram_rdata.valid) begin
               if (!found_ff && ram_rdata.key_lo == lo_ff && ram_rdata.key_hi == hi_ff) begin
                  found_in = 1'b1; hit_in = cur_ff; hit_ent_in = ram_rdata;
               end
            end else if (!free_ff) begin
               free_in = 1'b1; free_slot_in = cur_ff;
            end
            probe_in = probe_ff + PRB_W'(1);
         end
         FSM_DECIDE: begin
            rsp_in = '{status: RS_NOT_FOUND, conn_state: 3'd0, conn_number: 16'd0,
                       packet_count: 32'd0};
            if (do_update) begin
               hit_ent_in.conn_state = advance_state(hit_ent_ff.conn_state, req_ff.flag_syn,
                  req_ff.flag_ack, req_ff.flag_fin, req_ff.flag_rst);
               if (hit_ent_ff.count != '1) hit_ent_in.count = hit_ent_ff.count + 32'd1;
               rsp_in.status = RS_UPDATED;
               rsp_in.conn_state = hit_ent_in.conn_state;
               rsp_in.conn_number = hit_ent_ff.number;
               rsp_in.packet_count = hit_ent_in.count;
            end else if (do_create) begin
               hit_ent_in.valid = 1'b1;
               hit_ent_in.key_lo = lo_ff; hit_ent_in.key_hi = hi_ff;
               hit_ent_in.conn_state = initial_state(req_ff.flag_syn, req_ff.flag_ack,
                  req_ff.flag_fin, req_ff.flag_rst);
               hit_ent_in.number = next_num_ff;
               hit_ent_in.count = 32'd1;
               rsp_in.status = RS_CREATED;
               rsp_in.conn_state = hit_ent_in.conn_state;
               rsp_in.conn_number = next_num_ff;
               rsp_in.packet_count = 32'd1;
            end else if (req_ff.action == ACT_PACKET) begin
               rsp_in.status = RS_FULL;
            end else if (do_remove) begin
               hit_ent_in.valid = 1'b0;
               rsp_in.status = RS_REMOVED;
               rsp_in.conn_state = hit_ent_ff.conn_state;
               rsp_in.conn_number = hit_ent_ff.number;
               rsp_in.packet_count = hit_ent_ff.count;
            end
         end
         FSM_CLEAR: begin
            rsp_in = '{status: RS_CLEARED, conn_state: 3'd0, conn_number: 16'd0,
                       packet_count: 32'd0};
         end
         default: ;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_CLEAR;
         clr_addr_ff <= '0;
         clr_rsp_ff <= 1'b0;
         next_num_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == FSM_MIX && req_ff.action == ACT_CLEAR) begin
            clr_addr_ff <= '0;
            clr_rsp_ff <= 1'b1;
         end
         if (state_ff == FSM_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + IDX_W'(1);
            next_num_ff <= '0;
         end
         if (state_ff == FSM_WRITE && do_create) next_num_ff <= next_num_ff + 16'd1;
      end
      if (state_ff == FSM_IDLE && req_ch.valid) begin
         req_ff <= req_ch.payload;
         lo_ff <= (ka < kb) ? ka : kb;
         hi_ff <= (ka < kb) ? kb : ka;
      end
      if (hash_done) base_ff <= hash_base;
      if (state_ff == FSM_ISSUE) cur_ff <= probe_addr;
      probe_ff <= probe_in; found_ff <= found_in; free_ff <= free_in;
      hit_ff <= hit_in; free_slot_ff <= free_slot_in; hit_ent_ff <= hit_ent_in;
      rsp_ff <= rsp_in;
   end

   assign req_ch.ready   = state_ff == FSM_IDLE;
   assign rsp_ch.valid   = state_ff == FSM_RESPOND;
   assign rsp_ch.payload = rsp_ff;

   // no new transfer accepted while a result waits
   assert property (@(posedge clock) disable iff (reset) rsp_ch.valid |-> !req_ch.ready)
      else $error("req accepted during response");
   // a stalled result stays until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid && $stable(rsp_ch.payload))
      else $error("response dropped while stalled");
   // memory writes only in the write step or the clearing pass
   assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == FSM_WRITE || state_ff == FSM_CLEAR))
      else $error("stray table write");
endmodule

[dv/tb.sv]
// testbench for tcp_connection_tracker: directed, table-full, pressure and random tests
// depends on tct_pkg, tct_stream_if and the rtl of the block
`timescale 1ns / 1ps

module tb;
   import tct_pkg::*;

   localparam int ENTRIES   = DEF_TABLE_ENTRIES;
   localparam int PROBES    = DEF_MAX_PROBES;
   localparam int HOLD_LEN  = 400;
   localparam int POOL_SIZE = 48;

   logic clock;
   logic reset;

   tct_stream_if #(.payload_type(req_type)) req_if (clock);
   tct_stream_if #(.payload_type(rsp_type)) rsp_if (clock);

   tcp_connection_tracker u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if.sink),
      .rsp_ch (rsp_if.source)
   );

   // shadow copy of the connection table
   bit          shadow_valid [ENTRIES];
   bit [47:0]   shadow_lo    [ENTRIES];
   bit [47:0]   shadow_hi    [ENTRIES];
   bit [2:0]    shadow_state [ENTRIES];
   bit [15:0]   shadow_num   [ENTRIES];
   bit [31:0]   shadow_cnt   [ENTRIES];
   bit [15:0]   shadow_next_num;

   rsp_type     pending_rsp[$];
   int          mismatches;
   int          send_idle_pct;
   int          recv_stall_pct;
   int          hold_ask;
   int          hold_seen;
   int          hold_left;

   // key pool for random traffic
   bit [31:0]   pool_addr_a [POOL_SIZE];
   bit [31:0]   pool_addr_b [POOL_SIZE];
   bit [15:0]   pool_port_a [POOL_SIZE];
   bit [15:0]   pool_port_b [POOL_SIZE];

   initial clock = 1'b0;
   always #2 clock = ~clock;

   initial begin
      #4000000;
      $display("tcp_connection_tracker: mismatch");
      $finish;
   end

   function automatic int unsigned home_slot(bit [63:0] lo, bit [63:0] hi);
      bit [63:0] x;
      x = lo ^ ((hi << 13) | (hi >> 51));
      x = x * 64'h9E3779B97F4A7C15;
      x = x ^ (x >> 29);
      return int'((x >> 16) % ENTRIES);
   endfunction

   function automatic void order_key(req_type r, output bit [47:0] lo, output bit [47:0] hi);
      bit [47:0] a;
      bit [47:0] b;
      a = {r.src_addr, r.src_port};
      b = {r.dst_addr, r.dst_port};
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
   endfunction

   // expected result of one request, updating the shadow table
   function automatic rsp_type track_request(req_type r);
      bit [47:0]   lo;
      bit [47:0]   hi;
      int unsigned base;
      int unsigned s;
      bit          found;
      bit          have_free;
      int unsigned hit;
      int unsigned free_slot;
      bit [2:0]    c;
      rsp_type     o;
      order_key(r, lo, hi);
      base = home_slot({16'd0, lo}, {16'd0, hi});
      found = 0;
      have_free = 0;
      hit = 0;
      free_slot = 0;
      o = '0;
      o.status = RS_NOT_FOUND;
      // every probe slot is checked, holes do not stop the search
      for (int i = 0; i < PROBES; i++) begin
         s = (base + i) % ENTRIES;
         if (shadow_valid[s]) begin
            if (!found && shadow_lo[s] == lo && shadow_hi[s] == hi) begin
               found = 1;
               hit = s;
            end
         end else if (!have_free) begin
            have_free = 1;
            free_slot = s;
         end
      end
      case (action_type'(r.action))
         ACT_PACKET: begin
            if (found) begin
               c = r.flag_rst ? 3'(ST_RESET) : shadow_state[hit];
               case (conn_state_type'(c))
                  ST_SYN_SENT:    if (r.flag_syn && r.flag_ack) c = ST_SYN_RCVD;
                  ST_SYN_RCVD:    if (r.flag_ack) c = ST_ESTABLISHED;
                  ST_ESTABLISHED: if (r.flag_fin) c = ST_CLOSING;
                  ST_CLOSING:     if (r.flag_fin) c = ST_CLOSED;
                  default: ;
               endcase
               shadow_state[hit] = c;
               if (shadow_cnt[hit] != 32'hFFFF_FFFF) shadow_cnt[hit] = shadow_cnt[hit] + 1;
               o.status = RS_UPDATED;
               o.conn_state = c;
               o.conn_number = shadow_num[hit];
               o.packet_count = shadow_cnt[hit];
            end else if (have_free) begin
               if (r.flag_syn)      c = r.flag_ack ? ST_SYN_RCVD : ST_SYN_SENT;
               else if (r.flag_rst) c = ST_RESET;
               else if (r.flag_fin) c = ST_CLOSING;
               else                 c = ST_ESTABLISHED;
               shadow_valid[free_slot] = 1;
               shadow_lo[free_slot] = lo;
               shadow_hi[free_slot] = hi;
               shadow_state[free_slot] = c;
               shadow_num[free_slot] = shadow_next_num;
               shadow_cnt[free_slot] = 1;
               o.status = RS_CREATED;
               o.conn_state = c;
               o.conn_number = shadow_next_num;
               o.packet_count = 1;
               shadow_next_num = shadow_next_num + 1;
            end else begin
               o.status = RS_FULL;
            end
         end
         ACT_REMOVE: begin
            if (found) begin
               shadow_valid[hit] = 0;
               o.status = RS_REMOVED;
               o.conn_state = shadow_state[hit];
               o.conn_number = shadow_num[hit];
               o.packet_count = shadow_cnt[hit];
            end
         end
         ACT_CLEAR: begin
            for (int i = 0; i < ENTRIES; i++) shadow_valid[i] = 0;
            shadow_next_num = 0;
            o.status = RS_CLEARED;
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic req_type make_req(action_type act, bit [31:0] sa, bit [31:0] da,
                                        bit [15:0] sp, bit [15:0] dp, bit [3:0] flags);
      req_type r;
      r.action = act;
      r.src_addr = sa;
      r.dst_addr = da;
      r.src_port = sp;
      r.dst_port = dp;
      {r.flag_syn, r.flag_ack, r.flag_fin, r.flag_rst} = flags;
      return r;
   endfunction

   // one request transfer, called at a rising edge
   task automatic send_req(req_type r);
      req_if.valid <= 1'b1;
      req_if.payload <= r;
      do @(posedge clock); while (!req_if.ready);
      pending_rsp.push_back(track_request(r));
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic drain;
      req_if.valid <= 1'b0;
      while (pending_rsp.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // compare one response transfer against the oldest expectation
   task automatic check_rsp(rsp_type got);
      rsp_type want;
      if (pending_rsp.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected response %p", got);
         return;
      end
      want = pending_rsp.pop_front();
      if (got.status !== want.status || got.conn_state !== want.conn_state ||
          got.conn_number !== want.conn_number || got.packet_count !== want.packet_count)
      begin
         mismatches++;
         if (mismatches <= 10)
            $display("response differs: expected %p, actual %p", want, got);
      end
   endtask

   // response side: random stalls, plus a long hold on request
   initial begin
      rsp_if.ready = 1'b0;
      hold_seen = 0;
      hold_left = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) check_rsp(rsp_if.payload);
         if (hold_ask != hold_seen) begin
            hold_seen <= hold_ask;
            hold_left <= HOLD_LEN;
            rsp_if.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic test_directed;
      send_req(make_req(ACT_CLEAR, 0, 0, 0, 0, 4'b0000));
      // extreme keys: all zeros, then the all-ones key twice with different flags
      send_req(make_req(ACT_PACKET, 32'h0, 32'h0, 16'h0, 16'h0, 4'b0000));
      send_req(make_req(ACT_PACKET, '1, '1, '1, '1, 4'b1111));
      send_req(make_req(ACT_PACKET, '1, '1, '1, '1, 4'b0000));
      // handshake walk: syn, syn+ack, ack, fin, fin, rst
      send_req(make_req(ACT_PACKET, 32'h0A000001, 32'hC0A80002, 16'd1234, 16'd80, 4'b1000));
      send_req(make_req(ACT_PACKET, 32'hC0A80002, 32'h0A000001, 16'd80, 16'd1234, 4'b1100));
      send_req(make_req(ACT_PACKET, 32'h0A000001, 32'hC0A80002, 16'd1234, 16'd80, 4'b0100));
      send_req(make_req(ACT_PACKET, 32'h0A000001, 32'hC0A80002, 16'd1234, 16'd80, 4'b0010));
      send_req(make_req(ACT_PACKET, 32'hC0A80002, 32'h0A000001, 16'd80, 16'd1234, 4'b0010));
      send_req(make_req(ACT_PACKET, 32'hC0A80002, 32'h0A000001, 16'd80, 16'd1234, 4'b0001));
      // new entries from syn+ack, rst and fin, then an update of the rst entry
      send_req(make_req(ACT_PACKET, 32'h1, 32'h2, 16'd3, 16'd4, 4'b1100));
      send_req(make_req(ACT_PACKET, 32'h5, 32'h6, 16'd7, 16'd8, 4'b0001));
      send_req(make_req(ACT_PACKET, 32'h9, 32'hA, 16'd11, 16'd12, 4'b0010));
      send_req(make_req(ACT_PACKET, 32'h5, 32'h6, 16'd7, 16'd8, 4'b1110));
      // remove found, remove again, undefined action, clear, packet after the clear
      send_req(make_req(ACT_REMOVE, 32'hC0A80002, 32'h0A000001, 16'd80, 16'd1234, 4'b0000));
      send_req(make_req(ACT_REMOVE, 32'h0A000001, 32'hC0A80002, 16'd1234, 16'd80, 4'b0000));
      send_req(make_req(ACT_UNDEF, 32'h1, 32'h2, 16'd3, 16'd4, 4'b1111));
      send_req(make_req(ACT_CLEAR, '1, '1, '1, '1, 4'b1111));
      send_req(make_req(ACT_PACKET, 32'h1, 32'h2, 16'd3, 16'd4, 4'b0100));
      drain();
   endtask

   // keys that all hash to one home slot fill the probe window
   task automatic test_full_table;
      req_type     same_home[$];
      req_type     r;
      bit [47:0]   lo;
      bit [47:0]   hi;
      int unsigned target;
      target = $urandom_range(ENTRIES - 1);
      while (same_home.size() < PROBES + 2) begin
         r = make_req(ACT_PACKET, $urandom, $urandom, $urandom, $urandom, 4'($urandom));
         order_key(r, lo, hi);
         if (home_slot({16'd0, lo}, {16'd0, hi}) == target) same_home.push_back(r);
      end
      send_req(make_req(ACT_CLEAR, 0, 0, 0, 0, 4'b0000));
      for (int i = 0; i < PROBES + 1; i++) send_req(same_home[i]);
      // free a slot in the middle, entries beyond it must still be found
      r = same_home[2];
      r.action = ACT_REMOVE;
      send_req(r);
      send_req(same_home[PROBES - 1]);
      send_req(same_home[PROBES + 1]);
      send_req(same_home[PROBES]);
      send_req(same_home[2]);
      drain();
   endtask

   // long response hold while requests keep coming
   task automatic test_backpressure;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_ask = hold_ask + 1;
      for (int i = 0; i < 30; i++)
         send_req(make_req(ACT_PACKET, $urandom_range(3), 32'h7, $urandom_range(3), 16'd9,
                           4'($urandom)));
      drain();
   endtask

   task automatic test_random(int count, int idle_pct, int stall_pct);
      req_type r;
      int      k;
      int      pick;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 85) begin
            k = $urandom_range(POOL_SIZE - 1);
            if ($urandom_range(1))
               r = make_req(ACT_PACKET, pool_addr_a[k], pool_addr_b[k], pool_port_a[k],
                            pool_port_b[k], 4'($urandom));
            else
               r = make_req(ACT_PACKET, pool_addr_b[k], pool_addr_a[k], pool_port_b[k],
                            pool_port_a[k], 4'($urandom));
         end else begin
            r = make_req(ACT_PACKET, $urandom, $urandom, $urandom, $urandom, 4'($urandom));
         end
         pick = $urandom_range(99);
         if (pick < 14)      r.action = ACT_REMOVE;
         else if (pick < 16) r.action = ACT_CLEAR;
         else if (pick < 19) r.action = ACT_UNDEF;
         send_req(r);
      end
      drain();
   endtask

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      mismatches = 0;
      hold_ask = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      shadow_next_num = 0;
      for (int i = 0; i < ENTRIES; i++) shadow_valid[i] = 0;
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_addr_a[i] = $urandom;
         pool_addr_b[i] = $urandom;
         pool_port_a[i] = $urandom;
         pool_port_b[i] = $urandom;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_full_table();
      test_backpressure();
      test_random(450, 0, 0);
      test_random(450, 62, 0);
      test_random(450, 0, 62);
      test_random(450, 38, 38);

      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("tcp_connection_tracker: match");
      else
         $display("tcp_connection_tracker: mismatch");
      $finish;
   end

endmodule
